// ===== src/stkspan_pkg.sv =====
// ----------------------------------------------------------------------------
// stkspan_pkg
// Shared types and constants for the stock span block: field widths and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package stkspan_pkg;

  // Fixed widths of the channel fields
  localparam int PRICE_IN_W = 32;
  localparam int SPAN_W     = 11;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;    // latch the incoming request, clear on first
    logic pop;       // drop top entry, fetch the one below
    logic load_top;  // move fetched entry into the top cache
    logic push;      // push price, emit normal span
    logic emit_ovf;  // emit saturated span with overflow set
  } stkspan_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ovf;       // sequence already at full length
    logic pop_cond;  // stack not empty and price beats the top
    logic last_pop;  // exactly one entry left on the stack
    logic out_free;  // result register can take a new result
  } stkspan_sts_t;

endpackage

// ===== src/stkspan_if.sv =====
// ----------------------------------------------------------------------------
// stkspan_in_if / stkspan_out_if
// Valid/ready channels for price requests and span results.
// ----------------------------------------------------------------------------
interface stkspan_in_if
  import stkspan_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_IN_W-1:0] price;
  logic                  first;

  modport source (output valid, price, first, input ready);
  modport sink   (input valid, price, first, output ready);
endinterface

interface stkspan_out_if
  import stkspan_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [SPAN_W-1:0] span;
  logic              overflow;

  modport source (output valid, span, overflow, input ready);
  modport sink   (input valid, span, overflow, output ready);
endinterface

// ===== src/stkspan_ctrl.sv =====
// ----------------------------------------------------------------------------
// stkspan_ctrl
// Controller: per request, a saturated span on overflow; else pops while the
// price beats the top, then pushes; each span goes to the result register.
// ----------------------------------------------------------------------------
module stkspan_ctrl
  import stkspan_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  stkspan_sts_t sts,
  output stkspan_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    CHECK,
    LOAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   rdy;

  assign in_ready = rdy;

  // Command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid && rdy) begin
          cmd.accept = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (sts.ovf) begin
          if (sts.out_free) begin
            cmd.emit_ovf = 1'b1;
            state_next   = IDLE;
          end
        end else if (sts.pop_cond) begin
          cmd.pop    = 1'b1;
          // stack empties: nothing to fetch
          state_next = sts.last_pop ? CHECK : LOAD;
        end else if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = IDLE;
        end
      end
      LOAD: begin
        cmd.load_top = 1'b1;
        state_next   = CHECK;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      rdy   <= 1'b1;
    end else begin
      state <= state_next;
      rdy   <= (state_next == IDLE);
    end
  end

endmodule

// ===== src/stkspan_dp.sv =====
// ----------------------------------------------------------------------------
// stkspan_dp
// Datapath: stack memory of (position, price) pairs, cached top entry,
// stack count, position counter, span arithmetic and result register.
// ----------------------------------------------------------------------------
module stkspan_dp
  import stkspan_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [PRICE_IN_W-1:0] in_price,
  input  logic                  in_first,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SPAN_W-1:0]     out_span,
  output logic                  out_overflow,
  input  stkspan_cmd_t          cmd,
  output stkspan_sts_t          sts
);

  localparam int IdxW = $clog2(MAX_LEN);
  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam logic [CntW-1:0] MaxLenC = CntW'(MAX_LEN);

  typedef struct packed {
    logic [IdxW-1:0]       pos;
    logic [PRICE_BITS-1:0] val;
  } entry_t;

  // Stack memory, one write and one registered read port
  entry_t mem [MAX_LEN];

  logic [PRICE_BITS-1:0] price_q;
  logic [CntW-1:0]       count;
  logic [CntW-1:0]       position;
  entry_t                top;
  entry_t                rd;
  entry_t                wr;
  logic [IdxW-1:0]       wr_addr;
  logic [IdxW-1:0]       rd_addr;
  logic [CntW-1:0]       count_m2;
  logic [CntW-1:0]       span_full;
  logic [2*PRICE_IN_W-1:0] price_wide;

  // Only the low PRICE_BITS of the price take part
  assign price_wide = {{PRICE_IN_W{1'b0}}, in_price};

  assign count_m2 = count - CntW'(2);
  assign rd_addr  = IdxW'(count_m2);
  assign wr_addr  = IdxW'(count);
  assign wr.pos   = IdxW'(position);
  assign wr.val   = price_q;

  // Span: distance to the surviving top, or full prefix when empty
  assign span_full = (count == '0) ? position + CntW'(1)
                                   : position - CntW'(top.pos);

  // Status
  assign sts.ovf      = (position >= MaxLenC);
  assign sts.pop_cond = (count != '0) && (price_q > top.val);
  assign sts.last_pop = (count == CntW'(1));
  assign sts.out_free = !out_valid || out_ready;

  // Stack memory
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= wr;
    end
    if (cmd.pop) begin
      rd <= mem[rd_addr];
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      position <= '0;
    end else if (cmd.accept && in_first) begin
      count    <= '0;
      position <= '0;
    end else if (cmd.pop) begin
      count <= count - CntW'(1);
    end else if (cmd.push) begin
      count    <= count + CntW'(1);
      position <= position + CntW'(1);
    end
  end

  // Request price and top-of-stack cache
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      price_q <= price_wide[PRICE_BITS-1:0];
    end
    if (cmd.push) begin
      top <= wr;
    end else if (cmd.load_top) begin
      top <= rd;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push || cmd.emit_ovf) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_span     <= SPAN_W'(span_full);
      out_overflow <= 1'b0;
    end else if (cmd.emit_ovf) begin
      out_span     <= SPAN_W'(MAX_LEN);
      out_overflow <= 1'b1;
    end
  end

endmodule

// ===== src/stock_span_monotonic_stack_top.sv =====
// Stock span on a monotonic stack. Each price request returns one result:
// the span (count of consecutive prices up to this one that lie below it,
// this one included) and an overflow flag once a sequence runs past MAX_LEN
// prices. Each pop reads the entry below from the stack memory and then
// loads it into the top-of-stack register, except that the pop which
// empties the stack has nothing below to fetch. A request waits for the
// previous result to leave the output register before it hands on its own.
// Every price up to MAX_LEN in a sequence is pushed once and popped at most
// once. A new request is taken while the previous result still waits in the
// output register. The stack memory holds MAX_LEN entries of
// $clog2(MAX_LEN) + PRICE_BITS bits and needs no clearing after reset.
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack_top
// Top level: joins the controller and the datapath to the channels.
// ----------------------------------------------------------------------------
module stock_span_monotonic_stack_top
  import stkspan_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int PRICE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  stkspan_in_if.sink   in_ch,
  stkspan_out_if.source out_ch
);

  stkspan_cmd_t cmd;
  stkspan_sts_t sts;

  stkspan_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stkspan_dp #(
    .MAX_LEN    (MAX_LEN),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_price     (in_ch.price),
    .in_first     (in_ch.first),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_span     (out_ch.span),
    .out_overflow (out_ch.overflow),
    .cmd          (cmd),
    .sts          (sts)
  );

  // A result is only written into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.push || cmd.emit_ovf) |-> (!out_ch.valid || out_ch.ready))
    else $error("result written over a pending result");

  // A pop only happens when the price beats a stacked entry
  a_pop_cond: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (sts.pop_cond && !sts.ovf))
    else $error("pop without a lower top entry");

  // At most one datapath action per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.pop, cmd.load_top, cmd.push, cmd.emit_ovf}))
    else $error("conflicting datapath commands");

  // One request at a time: no new request right after one is taken
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request taken while one is in work");

endmodule

// ===== test/stock_span_monotonic_stack_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack_top_test
// Self-checking bench for the stock span block. Price requests go in with
// random gaps and span results come out under random stalls. An in-bench
// span predictor with its own monotonic stack computes every result, and
// each result is checked field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module stock_span_monotonic_stack_top_test;
  import stkspan_pkg::*;

  localparam int MAX_LEN      = 1024;
  localparam int PRICE_BITS   = 32;
  localparam int POS_W        = $clog2(MAX_LEN);
  localparam int IDLE_LIMIT   = 20000;  // room for a full-stack unwind
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 60;
  localparam int EXP_DEPTH    = 16;     // at most two results in flight

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic              overflow;
  } span_result_t;

  typedef enum int {
    PRICE_UNIFORM,
    PRICE_TIES,
    PRICE_RISING,
    PRICE_FALLING,
    PRICE_SAWTOOTH
  } price_style_t;

  logic clk;
  logic rst;

  stkspan_in_if  in_ch ();
  stkspan_out_if out_ch ();

  stock_span_monotonic_stack_top #(
    .MAX_LEN    (MAX_LEN),
    .PRICE_BITS (PRICE_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: stacked (position, price) pairs of the open sequence
  logic [POS_W-1:0]      stack_pos   [MAX_LEN];
  logic [PRICE_IN_W-1:0] stack_price [MAX_LEN];
  int                    stack_depth = 0;
  int                    seq_pos     = 0;

  // Expected results, oldest at exp_rd
  span_result_t exp_fifo [EXP_DEPTH];
  int           exp_wr      = 0;
  int           exp_rd      = 0;
  int           errors      = 0;
  int           idle_cycles = 0;
  bit           steady      = 1'b0;  // no gaps or stalls while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Span of one price request; updates the predictor's stack
  function automatic span_result_t predict_span(input logic [PRICE_IN_W-1:0] price,
                                                input logic first);
    span_result_t res;
    int           span;
    if (first) begin
      stack_depth = 0;
      seq_pos     = 0;
    end
    // past MAX_LEN: saturate, state untouched
    if (seq_pos >= MAX_LEN) begin
      res.span     = SPAN_W'(MAX_LEN);
      res.overflow = 1'b1;
      return res;
    end
    // pop strictly lower prices; an equal price stays and ends the span
    while (stack_depth > 0 && price > stack_price[stack_depth-1])
      stack_depth--;
    if (stack_depth == 0)
      span = seq_pos + 1;
    else
      span = seq_pos - int'(stack_pos[stack_depth-1]);
    if (stack_depth < MAX_LEN) begin
      stack_pos[stack_depth]   = POS_W'(seq_pos);
      stack_price[stack_depth] = price;
      stack_depth++;
    end
    seq_pos++;
    res.span     = SPAN_W'(span);
    res.overflow = 1'b0;
    return res;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (steady)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one price request and wait for it to be taken
  task automatic send_price_request(input logic [PRICE_IN_W-1:0] price, input logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.price <= price;
    in_ch.first <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Result side: random stalls on ready
  initial begin : sink_ready
    int stall;
    int hold;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      hold = steady ? 50 : $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
    end
  end

  // Predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    span_result_t want;
    if (in_ch.valid && in_ch.ready) begin
      exp_fifo[exp_wr % EXP_DEPTH] = predict_span(in_ch.price, in_ch.first);
      exp_wr++;
    end
    if (out_ch.valid && out_ch.ready) begin
      if (exp_rd == exp_wr) begin
        $error("unexpected result: span %0d, overflow %0b", out_ch.span, out_ch.overflow);
        errors++;
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_ch.span !== want.span) begin
          $error("span mismatch: expected %0d, actual %0d", want.span, out_ch.span);
          errors++;
        end
        if (out_ch.overflow !== want.overflow) begin
          $error("overflow mismatch: expected %0b, actual %0b", want.overflow,
                 out_ch.overflow);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hand-picked corner cases
  task automatic test_directed();
    // no first flag after reset: starts at position 0
    send_price_request(32'd100, 1'b0);
    // equal price does not pop
    send_price_request(32'd100, 1'b0);
    send_price_request(32'd50, 1'b0);
    send_price_request(32'd0, 1'b0);
    // pops lower entries, stops at the equal one
    send_price_request(32'd100, 1'b0);
    // top price empties the stack
    send_price_request(32'hFFFF_FFFF, 1'b0);
    send_price_request(32'hFFFF_FFFF, 1'b0);
    // new sequences, back to back
    send_price_request(32'hFFFF_FFFF, 1'b1);
    send_price_request(32'd0, 1'b1);
    // rising run: spans grow
    for (int k = 1; k <= 6; k++)
      send_price_request(32'(k), 1'b0);
    // falling run: spans of one, then a climb back over ties
    send_price_request(32'hAAAA_AAAA, 1'b1);
    send_price_request(32'h5555_5555, 1'b0);
    send_price_request(32'h5555_5554, 1'b0);
    send_price_request(32'h0000_0001, 1'b0);
    send_price_request(32'h5555_5555, 1'b0);
    send_price_request(32'hAAAA_AAAA, 1'b0);
    send_price_request(32'hAAAA_AAAB, 1'b0);
  endtask

  // Short sequences with assorted price shapes
  task automatic test_random_sequences();
    int           sent;
    int           len;
    int           roll;
    price_style_t style;
    logic [31:0]  level;
    logic [31:0]  price;
    logic         first;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)
        len = $urandom_range(1, 12);
      else if (roll < 95)
        len = $urandom_range(13, 60);
      else
        len = $urandom_range(61, 200);
      // keep the item count on budget
      if (len > RANDOM_ITEMS - sent)
        len = RANDOM_ITEMS - sent;
      style  = price_style_t'($urandom_range(0, 4));
      steady = ($urandom_range(0, 4) == 0);
      level  = $urandom();
      for (int k = 0; k < len; k++) begin
        case (style)
          PRICE_UNIFORM: begin
            price = $urandom();
          end
          PRICE_TIES: begin
            price = {level[31:3], 3'($urandom_range(0, 7))};
          end
          PRICE_RISING: begin
            level = level + $urandom_range(0, 4000) - 500;
            price = level;
          end
          PRICE_FALLING: begin
            level = level - $urandom_range(0, 4000) + 500;
            price = level;
          end
          default: begin
            if (k % 8 == 0)
              level = $urandom();
            else
              level = level - $urandom_range(0, 100);
            price = level;
          end
        endcase
        // mostly a flag on the opening price, now and then a restart midway
        if (k == 0)
          first = ($urandom_range(0, 9) != 0);
        else
          first = ($urandom_range(0, 49) == 0);
        send_price_request(price, first);
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // One sequence past MAX_LEN: deep stack, full-length span, then saturation
  task automatic test_overflow();
    logic [31:0] level;
    level = 32'hF000_0000;
    send_price_request(level, 1'b1);
    // mostly falling so the stack grows deep; small bumps pop a few
    for (int k = 1; k < MAX_LEN - 1; k++) begin
      if ($urandom_range(0, 9) == 0)
        level = level + $urandom_range(0, 6);
      else
        level = level - $urandom_range(0, 3);
      send_price_request(level, 1'b0);
    end
    // last position: beats everything stacked, span hits MAX_LEN
    send_price_request(32'hFFFF_FFFF, 1'b0);
    // sequence too long: saturated span with overflow
    for (int k = 0; k < 12; k++)
      send_price_request($urandom(), 1'b0);
    // a new sequence clears the overflow
    send_price_request($urandom(), 1'b1);
    for (int k = 0; k < 5; k++)
      send_price_request($urandom(), 1'b0);
  endtask

  initial begin
    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.price <= '0;
    in_ch.first <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_sequences();
    test_overflow();

    in_ch.valid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/stkspan_pkg.sv
src/stkspan_if.sv
src/stkspan_ctrl.sv
src/stkspan_dp.sv
src/stock_span_monotonic_stack_top.sv
test/stock_span_monotonic_stack_top_test.sv
